FILE: rtl/core/rc4_pkg.sv
package rc4_pkg;

    localparam int KEY_MAX_DEF = 256;
    localparam int PC_W        = 4;

    // Request kinds
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef enum logic [1:0] {
        MEM_IDLE,
        MEM_READ,
        MEM_WRITE
    } mem_op_t;

    typedef enum logic [1:0] {
        ADDR_N,
        ADDR_I,
        ADDR_J,
        ADDR_T
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_N,
        WD_RD,
        WD_A
    } wdata_sel_t;

    typedef enum logic [1:0] {
        J_HOLD,
        J_KSA,
        J_PRGA,
        J_CLEAR
    } j_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP,
        JMP_END
    } jump_t;

    typedef struct packed {
        mem_op_t          mem_op;
        addr_sel_t        addr_sel;
        wdata_sel_t       wd_sel;
        j_op_t            j_op;
        logic             i_inc;
        logic             n_inc;
        logic             kp_inc;
        logic             kp_clr;
        logic             a_load;
        logic             b_load;
        logic             t_load;
        logic             out_load;
        logic             finish;
        jump_t            jump;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic       we;
        logic [7:0] data;
    } key_wr_t;

    // Program entry points
    localparam logic [PC_W-1:0] PC_KSA  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_PRGA = PC_W'(7);

    // Control store
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t cw;
        cw = '0;
        case (pc)
            // identity fill, one entry a step
            4'd0:
            begin
                cw.mem_op   = MEM_WRITE;
                cw.addr_sel = ADDR_N;
                cw.wd_sel   = WD_N;
                cw.j_op     = J_CLEAR;
                cw.kp_clr   = 1'b1;
                cw.n_inc    = 1'b1;
                cw.jump     = JMP_LOOP;
                cw.target   = PC_W'(0);
            end
            4'd1:
            begin
                cw.mem_op   = MEM_READ;
                cw.addr_sel = ADDR_N;
            end
            4'd2:
            begin
                cw.a_load = 1'b1;
                cw.j_op   = J_KSA;
            end
            4'd3:
            begin
                cw.mem_op   = MEM_READ;
                cw.addr_sel = ADDR_J;
            end
            4'd4:
            begin
                cw.mem_op   = MEM_WRITE;
                cw.addr_sel = ADDR_N;
                cw.wd_sel   = WD_RD;
            end
            4'd5:
            begin
                cw.mem_op   = MEM_WRITE;
                cw.addr_sel = ADDR_J;
                cw.wd_sel   = WD_A;
                cw.n_inc    = 1'b1;
                cw.kp_inc   = 1'b1;
                cw.jump     = JMP_LOOP;
                cw.target   = PC_W'(1);
            end
            4'd6:
            begin
                cw.finish = 1'b1;
                cw.jump   = JMP_END;
            end
            // keystream step
            4'd7:
            begin
                cw.i_inc = 1'b1;
            end
            4'd8:
            begin
                cw.mem_op   = MEM_READ;
                cw.addr_sel = ADDR_I;
            end
            4'd9:
            begin
                cw.a_load = 1'b1;
                cw.j_op   = J_PRGA;
            end
            4'd10:
            begin
                cw.mem_op   = MEM_READ;
                cw.addr_sel = ADDR_J;
            end
            4'd11:
            begin
                cw.mem_op   = MEM_WRITE;
                cw.addr_sel = ADDR_I;
                cw.wd_sel   = WD_RD;
                cw.b_load   = 1'b1;
            end
            4'd12:
            begin
                cw.mem_op   = MEM_WRITE;
                cw.addr_sel = ADDR_J;
                cw.wd_sel   = WD_A;
                cw.t_load   = 1'b1;
            end
            4'd13:
            begin
                cw.mem_op   = MEM_READ;
                cw.addr_sel = ADDR_T;
            end
            4'd14:
            begin
                cw.out_load = 1'b1;
                cw.jump     = JMP_END;
            end
            default:
            begin
                cw.jump = JMP_END;
            end
        endcase
        return cw;
    endfunction

endpackage

FILE: rtl/core/rc4_req_if.sv
interface rc4_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] byte_value;
    logic       key_last;

    modport source (output valid, output req_type, output byte_value, output key_last,
                    input ready);
    modport sink (input valid, input req_type, input byte_value, input key_last,
                  output ready);
endinterface

FILE: rtl/core/rc4_rsp_if.sv
interface rc4_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       not_keyed;

    modport source (output valid, output out_byte, output not_keyed, input ready);
    modport sink (input valid, input out_byte, input not_keyed, output ready);
endinterface

FILE: rtl/core/rc4_seq.sv
module rc4_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rc4_pkg::PC_W-1:0]  entry,
    input  logic                      stall,
    input  logic                      n_last,
    output rc4_pkg::ctrl_t            ctrl,
    output logic                      busy
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    seq_state_t                 state_reg, state_next;
    logic [rc4_pkg::PC_W-1:0]   pc_reg, pc_next;

    always_comb
    begin
        if (state_reg == SEQ_RUN)
            ctrl = rc4_pkg::ucode(pc_reg);
        else
            ctrl = '0;
    end

    assign busy = (state_reg == SEQ_RUN);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = entry;
                end
            end
            SEQ_RUN:
            begin
                if (!stall)
                begin
                    case (ctrl.jump)
                        rc4_pkg::JMP_NEXT: pc_next = pc_reg + rc4_pkg::PC_W'(1);
                        rc4_pkg::JMP_LOOP:
                        begin
                            if (n_last)
                                pc_next = pc_reg + rc4_pkg::PC_W'(1);
                            else
                                pc_next = ctrl.target;
                        end
                        default: state_next = SEQ_IDLE;
                    endcase
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

FILE: rtl/core/rc4_dp.sv
module rc4_dp #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rc4_pkg::ctrl_t     ctrl,
    input  rc4_pkg::key_wr_t   key_wr,
    output logic [7:0]         perm_rd,
    output logic               n_last,
    output logic               keyed
);

    localparam int KL_W = $clog2(KEY_MAX + 1);
    localparam int KI_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [7:0]      perm_mem [256];
    logic [7:0]      key_mem [KEY_MAX];

    logic [7:0]      perm_rd_reg;
    logic [7:0]      key_rd_reg;
    logic [7:0]      i_reg, i_next;
    logic [7:0]      j_reg, j_next;
    logic [7:0]      n_reg, n_next;
    logic [KI_W-1:0] kp_reg, kp_next;
    logic [KL_W-1:0] key_len_reg, key_len_next;
    logic            keyed_reg, keyed_next;
    logic [7:0]      a_reg, b_reg, t_reg;

    logic [7:0]      addr;
    logic [7:0]      wdata;
    logic            key_room;

    assign perm_rd  = perm_rd_reg;
    assign keyed    = keyed_reg;
    assign n_last   = (n_reg == 8'hFF);
    assign key_room = (key_len_reg < KL_W'(KEY_MAX));

    always_comb
    begin
        case (ctrl.addr_sel)
            rc4_pkg::ADDR_N: addr = n_reg;
            rc4_pkg::ADDR_I: addr = i_reg;
            rc4_pkg::ADDR_J: addr = j_reg;
            default:         addr = t_reg;
        endcase
        case (ctrl.wd_sel)
            rc4_pkg::WD_N:  wdata = n_reg;
            rc4_pkg::WD_RD: wdata = perm_rd_reg;
            default:        wdata = a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mem_op == rc4_pkg::MEM_WRITE)
            perm_mem[addr] <= wdata;
        else if (ctrl.mem_op == rc4_pkg::MEM_READ)
            perm_rd_reg <= perm_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (key_wr.we && key_room)
            key_mem[key_len_reg[KI_W-1:0]] <= key_wr.data;
        key_rd_reg <= key_mem[kp_reg];
    end

    always_comb
    begin
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        kp_next      = kp_reg;
        key_len_next = key_len_reg;
        keyed_next   = keyed_reg;

        if (ctrl.i_inc)
            i_next = i_reg + 8'd1;
        if (ctrl.n_inc)
            n_next = n_reg + 8'd1;

        case (ctrl.j_op)
            rc4_pkg::J_KSA:   j_next = j_reg + perm_rd_reg + key_rd_reg;
            rc4_pkg::J_PRGA:  j_next = j_reg + perm_rd_reg;
            rc4_pkg::J_CLEAR: j_next = '0;
            default:          j_next = j_reg;
        endcase

        // walk the key cyclically
        if (ctrl.kp_clr)
            kp_next = '0;
        else if (ctrl.kp_inc)
        begin
            if ((KL_W'(kp_reg) + KL_W'(1)) == key_len_reg)
                kp_next = '0;
            else
                kp_next = kp_reg + KI_W'(1);
        end

        if (key_wr.we && key_room)
            key_len_next = key_len_reg + KL_W'(1);

        if (ctrl.finish)
        begin
            i_next       = '0;
            j_next       = '0;
            key_len_next = '0;
            keyed_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            kp_reg      <= '0;
            key_len_reg <= '0;
            keyed_reg   <= 1'b0;
        end
        else
        begin
            i_reg       <= i_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            kp_reg      <= kp_next;
            key_len_reg <= key_len_next;
            keyed_reg   <= keyed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.a_load)
            a_reg <= perm_rd_reg;
        if (ctrl.b_load)
            b_reg <= perm_rd_reg;
        if (ctrl.t_load)
            t_reg <= a_reg + b_reg;
    end

endmodule

FILE: rtl/core/rc4_stream_cipher.sv
// RC4 stream cipher with on-line key loading.
// request channel: req_type selects a key byte or a data byte in byte_value;
// key_last on a key byte closes the key and starts the key schedule.
// result channel: one result per data byte, out_byte = byte XOR keystream,
// not_keyed set while no schedule has completed (byte passed unchanged).
// Timing:
//   key byte          : taken in the accept cycle, ready again next cycle.
//   key byte, last    : busy through a fill pass over all 256 entries, a
//                       swap pass over all 256 entries and a finishing step
//                       on the single-port permutation memory.
//   data byte, keyed  : busy through the keystream program; result
//                       registered from its last step; no new byte is
//                       taken until it ends. The memory has a single port.
//   data byte, unkeyed: result registered in the cycle after acceptance.
// Reset clears indices, key length and the keyed flag; memory contents are
// not cleared, and no clearing pass runs. A stalled result holds in the
// output register; the program waits on its last step until the slot frees,
// and no request is taken while the slot is full and not being read.
module rc4_stream_cipher #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rc4_req_if.sink   request,
    rc4_rsp_if.source result
);

    rc4_pkg::ctrl_t    ctrl;
    rc4_pkg::key_wr_t  key_wr;
    logic              busy;
    logic              stall;
    logic              start;
    logic [rc4_pkg::PC_W-1:0] entry;
    logic [7:0]        perm_rd;
    logic              n_last;
    logic              keyed;
    logic              in_fire;
    logic              out_free;
    logic              deliver;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              not_keyed_reg, not_keyed_next;
    logic [7:0]        val_reg;

    assign out_free      = !out_valid_reg || result.ready;
    assign request.ready = !busy && out_free;
    assign in_fire       = request.valid && request.ready;

    assign key_wr.we   = in_fire && (request.req_type == rc4_pkg::REQ_KEY);
    assign key_wr.data = request.byte_value;

    always_comb
    begin
        start = 1'b0;
        entry = rc4_pkg::PC_KSA;
        if (in_fire)
        begin
            if (request.req_type == rc4_pkg::REQ_KEY)
            begin
                start = request.key_last;
                entry = rc4_pkg::PC_KSA;
            end
            else
            begin
                start = keyed;
                entry = rc4_pkg::PC_PRGA;
            end
        end
    end

    // hold the final step until the output slot frees
    assign stall   = ctrl.out_load && !out_free;
    assign deliver = ctrl.out_load && out_free;

    rc4_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .entry  (entry),
        .stall  (stall),
        .n_last (n_last),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    rc4_dp #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .key_wr  (key_wr),
        .perm_rd (perm_rd),
        .n_last  (n_last),
        .keyed   (keyed)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        not_keyed_next = not_keyed_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (deliver)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = val_reg ^ perm_rd;
            not_keyed_next = 1'b0;
        end
        else if (in_fire && (request.req_type == rc4_pkg::REQ_DATA) && !keyed)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = request.byte_value;
            not_keyed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        not_keyed_reg <= not_keyed_next;
        if (in_fire)
            val_reg <= request.byte_value;
    end

    assign result.valid     = out_valid_reg;
    assign result.out_byte  = out_byte_reg;
    assign result.not_keyed = not_keyed_reg;

    a_last_key_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (request.req_type == rc4_pkg::REQ_KEY) && request.key_last |=> busy)
        else $error("closing key byte did not start the schedule");

    a_unkeyed_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (request.req_type == rc4_pkg::REQ_DATA) && !keyed
        |=> result.valid && result.not_keyed)
        else $error("unkeyed data byte not passed through");

    a_keyed_from_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(keyed) |-> $past(busy))
        else $error("keyed flag set outside the schedule");

endmodule
